// ===== design/cll_pkg.sv =====
// Shared types and codes for the cursor linked list engine.
// Holds the command and result item structs; depends on nothing else.
package cll_pkg;

    localparam int POS_BITS   = 8;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = 8;
    localparam int COUNT_BITS = 8;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [POS_BITS-1:0]   position;
        logic [VALUE_BITS-1:0] value;
    } cll_req_t;

    typedef struct packed {
        logic                  ok;
        logic [SLOT_BITS-1:0]  slot;
        logic [COUNT_BITS-1:0] count;
    } cll_rsp_t;

endpackage

// ===== design/cursor_linked_list_engine_top.sv =====
// Cursor linked list engine: an ordered list kept in a slot memory linked by index.
// Depends on cll_pkg for the command and result item types and the function codes.
//
// Usage:
//   A command item (req) is taken at a rising edge where start is high and busy is
//   low. func selects insert (store value at a one-based position) or delete (remove
//   the element at a position). Slot 0 heads the free chain, slot SLOTS-1 heads the
//   data chain, so SLOTS-2 elements fit.
//   Exactly one result item per command appears on rsp for one cycle with done high.
//   It carries ok, the slot allocated or freed (0 when refused) and the new count.
//   The receiver cannot stall; the result must be taken in that cycle.
// Sequencing:
//   A refused command gives its result the cycle after it is taken.
//   An insert takes the free head (S_INS_A, S_INS_B), walks the data chain one link
//   per cycle through the registered read of the link memory, and splices (S_INS_C);
//   a delete walks, unlinks and frees the slot (S_DEL_A to S_DEL_C). The next command
//   may be taken in the cycle its predecessor's result is shown.
// Reset:
//   rst_n clears the control state, then the block sweeps every slot of the link memory
//   to rebuild the free chain; busy stays high during that pass.
module cursor_linked_list_engine_top
    import cll_pkg::*;
#(
    parameter int SLOTS     = 256,
    parameter int DATA_BITS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  cll_req_t req,
    output logic     done,
    output cll_rsp_t rsp
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CMP_W = ((IDX_W > POS_BITS) ? IDX_W : POS_BITS) + 1;
    localparam logic [IDX_W-1:0] HEAD_SLOT = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0] FREE_SLOT = '0;
    localparam logic [CMP_W-1:0] CAPACITY  = CMP_W'(SLOTS - 2);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_INS_A = 4'd2;
    localparam logic [3:0] S_INS_B = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_INS_C = 4'd5;
    localparam logic [3:0] S_DEL_A = 4'd6;
    localparam logic [3:0] S_DEL_B = 4'd7;
    localparam logic [3:0] S_DEL_C = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic [IDX_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [IDX_W-1:0]     prev_reg, prev_next;
    logic [IDX_W-1:0]     fresh_reg, fresh_next;
    logic [POS_BITS-1:0]  rem_reg, rem_next;
    logic                 op_reg, op_next;
    logic [DATA_BITS-1:0] val_reg, val_next;
    logic                 done_reg, done_next;
    cll_rsp_t             rsp_reg, rsp_next;

    logic [IDX_W-1:0]     link_mem [SLOTS];
    logic [DATA_BITS-1:0] value_mem [SLOTS];
    logic [IDX_W-1:0]     link_rdata_reg;
    logic                 link_we;
    logic [IDX_W-1:0]     link_waddr;
    logic [IDX_W-1:0]     link_wdata;
    logic [IDX_W-1:0]     link_raddr;
    logic                 value_we;

    logic                 accept;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic                 ins_ok;
    logic                 del_ok;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign pos_ext = CMP_W'(req.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign ins_ok  = (req.position != '0) && (pos_ext <= cnt_ext + CMP_W'(1))
                     && (cnt_ext < CAPACITY);
    assign del_ok  = (req.position != '0) && (pos_ext <= cnt_ext);

    // Link and value memories: at most one write each per cycle; the link memory also has one registered read.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[fresh_reg] <= val_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        fresh_next = fresh_reg;
        rem_next   = rem_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_raddr = FREE_SLOT;
        value_we   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                link_we    = 1'b1;
                link_waddr = clr_reg;
                link_wdata = (clr_reg == HEAD_SLOT) ? FREE_SLOT : clr_reg + IDX_W'(1);
                clr_next   = clr_reg + IDX_W'(1);
                if (clr_reg == HEAD_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req.func;
                    val_next = DATA_BITS'(req.value);
                    cur_next = HEAD_SLOT;
                    rem_next = req.position - POS_BITS'(1);
                    if (req.func == FUNC_INSERT && ins_ok)
                    begin
                        link_raddr = FREE_SLOT;
                        state_next = S_INS_A;
                    end
                    else if (req.func == FUNC_DELETE && del_ok)
                    begin
                        link_raddr = HEAD_SLOT;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        done_next      = 1'b1;
                        rsp_next.ok    = 1'b0;
                        rsp_next.slot  = '0;
                        rsp_next.count = COUNT_BITS'(count_reg);
                    end
                end
            end
            S_INS_A:
            begin
                // Head of the free chain is the slot handed out.
                fresh_next = link_rdata_reg;
                link_raddr = link_rdata_reg;
                state_next = S_INS_B;
            end
            S_INS_B:
            begin
                link_we    = 1'b1;
                link_waddr = FREE_SLOT;
                link_wdata = link_rdata_reg;
                value_we   = 1'b1;
                link_raddr = HEAD_SLOT;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // The read data is the link of cur_reg.
                if (rem_reg == '0)
                begin
                    prev_next = cur_reg;
                    if (op_reg == FUNC_INSERT)
                    begin
                        link_we    = 1'b1;
                        link_waddr = fresh_reg;
                        link_wdata = link_rdata_reg;
                        state_next = S_INS_C;
                    end
                    else
                    begin
                        fresh_next = link_rdata_reg;
                        link_raddr = link_rdata_reg;
                        state_next = S_DEL_A;
                    end
                end
                else
                begin
                    cur_next   = link_rdata_reg;
                    link_raddr = link_rdata_reg;
                    rem_next   = rem_reg - POS_BITS'(1);
                end
            end
            S_INS_C:
            begin
                link_we        = 1'b1;
                link_waddr     = prev_reg;
                link_wdata     = fresh_reg;
                count_next     = count_reg + IDX_W'(1);
                done_next      = 1'b1;
                rsp_next.ok    = 1'b1;
                rsp_next.slot  = SLOT_BITS'(fresh_reg);
                rsp_next.count = COUNT_BITS'(count_reg + IDX_W'(1));
                state_next     = S_IDLE;
            end
            S_DEL_A:
            begin
                // Unlink the removed slot, then fetch the free head.
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = link_rdata_reg;
                link_raddr = FREE_SLOT;
                state_next = S_DEL_B;
            end
            S_DEL_B:
            begin
                link_we    = 1'b1;
                link_waddr = fresh_reg;
                link_wdata = link_rdata_reg;
                state_next = S_DEL_C;
            end
            S_DEL_C:
            begin
                link_we        = 1'b1;
                link_waddr     = FREE_SLOT;
                link_wdata     = fresh_reg;
                count_next     = count_reg - IDX_W'(1);
                done_next      = 1'b1;
                rsp_next.ok    = 1'b1;
                rsp_next.slot  = SLOT_BITS'(fresh_reg);
                rsp_next.count = COUNT_BITS'(count_reg - IDX_W'(1));
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        fresh_reg <= fresh_next;
        rem_reg   <= rem_next;
        op_reg    <= op_next;
        val_reg   <= val_next;
        rsp_reg   <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CAPACITY)
        else $error("element count exceeds capacity");

    a_walk_off_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (cur_reg != FREE_SLOT))
        else $error("data chain walk reached the free head");

    a_insert_counts_up: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.ok && op_reg == FUNC_INSERT)
            |-> (count_reg == $past(count_reg) + IDX_W'(1)))
        else $error("successful insert did not raise the count");

    a_refused_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !rsp_reg.ok) |-> ($stable(count_reg) && rsp_reg.slot == '0))
        else $error("refused command changed the count or reported a slot");

endmodule

// ===== tb/sv/cll_tb_pkg.sv =====
// Shadow of the cursor linked list used by the testbench to predict and check results.
// Depends on cll_pkg for the command and result item types and the function codes.
package cll_tb_pkg;
    import cll_pkg::*;

    localparam int LIST_SLOTS = 256;
    localparam int HEAD_SLOT  = LIST_SLOTS - 1;
    localparam int CAPACITY   = LIST_SLOTS - 2;

    class list_shadow;
        logic [SLOT_BITS-1:0] link_of [LIST_SLOTS];
        int                   length;
        int unsigned          mismatches;
        cll_rsp_t             awaited [$];

        function new();
            for (int i = 0; i < LIST_SLOTS; i++)
            begin
                link_of[i] = SLOT_BITS'(i + 1);
            end
            link_of[HEAD_SLOT] = '0;
            length     = 0;
            mismatches = 0;
        endfunction

        // Slot reached after following the given number of links from the data head.
        function logic [SLOT_BITS-1:0] slot_after(int steps);
            logic [SLOT_BITS-1:0] cur;
            cur = SLOT_BITS'(HEAD_SLOT);
            for (int n = 0; n < steps; n++)
            begin
                cur = link_of[cur];
            end
            return cur;
        endfunction

        // Applies an accepted command item to the shadow list and queues its result.
        function void note_command(cll_req_t c);
            cll_rsp_t             r;
            logic [SLOT_BITS-1:0] fresh;
            logic [SLOT_BITS-1:0] prev;
            logic [SLOT_BITS-1:0] gone;
            int                   pos;
            r   = '0;
            pos = int'(c.position);
            if (c.func == FUNC_INSERT)
            begin
                if (pos >= 1 && pos <= length + 1 && length < CAPACITY)
                begin
                    fresh         = link_of[0];
                    link_of[0]    = link_of[fresh];
                    prev          = slot_after(pos - 1);
                    link_of[fresh] = link_of[prev];
                    link_of[prev] = fresh;
                    length++;
                    r.ok   = 1'b1;
                    r.slot = fresh;
                end
            end
            else
            begin
                if (pos >= 1 && pos <= length)
                begin
                    prev          = slot_after(pos - 1);
                    gone          = link_of[prev];
                    link_of[prev] = link_of[gone];
                    link_of[gone] = link_of[0];
                    link_of[0]    = gone;
                    length--;
                    r.ok   = 1'b1;
                    r.slot = gone;
                end
            end
            r.count = COUNT_BITS'(length);
            awaited.push_back(r);
        endfunction

        function void check_result(cll_rsp_t got);
            cll_rsp_t want;
            if (awaited.size() == 0)
            begin
                $error("result item with none awaited: ok=%0d slot=%0d count=%0d",
                       got.ok, got.slot, got.count);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.ok !== want.ok)
            begin
                $error("ok: expected %0d, actual %0d", want.ok, got.ok);
                mismatches++;
            end
            if (got.slot !== want.slot)
            begin
                $error("slot: expected %0d, actual %0d", want.slot, got.slot);
                mismatches++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, actual %0d", want.count, got.count);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Testbench for cursor_linked_list_engine_top: directed and random insert/delete items.
// Depends on cll_pkg for the item types and on cll_tb_pkg for the shadow list.
module testbench
    import cll_pkg::*, cll_tb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 3000000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    cll_req_t req;
    logic     done;
    cll_rsp_t rsp;

    list_shadow shadow;
    int         idle_pct;
    bit         filling;

    cursor_linked_list_engine_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Holds the item on req until the block takes it, then notes it in the shadow.
    task automatic issue_command(input logic f, input int pos, input logic [31:0] val);
        cll_req_t c;
        int       gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        c.func     = f;
        c.position = POS_BITS'(pos);
        c.value    = val;
        start <= 1'b1;
        req   <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        shadow.note_command(c);
    endtask

    // Mostly legal positions; the list is driven toward full and back toward empty
    // so that the long walks and the full-list refusal are both reached.
    task automatic issue_random_command();
        logic f;
        int   len;
        int   pos;
        len = shadow.length;
        if (filling && len == CAPACITY && $urandom_range(3) == 0)
        begin
            filling = 1'b0;
        end
        else if (!filling && len == 0 && $urandom_range(3) == 0)
        begin
            filling = 1'b1;
        end
        if (filling)
        begin
            f = ($urandom_range(99) < 90) ? FUNC_INSERT : FUNC_DELETE;
        end
        else
        begin
            f = ($urandom_range(99) < 90) ? FUNC_DELETE : FUNC_INSERT;
        end
        if ($urandom_range(99) < 88)
        begin
            if (f == FUNC_INSERT)
            begin
                case ($urandom_range(3))
                    0: pos = 1;
                    1: pos = len + 1;
                    default: pos = $urandom_range(len + 1, 1);
                endcase
            end
            else if (len == 0)
            begin
                pos = $urandom_range(255, 1);
            end
            else
            begin
                case ($urandom_range(3))
                    0: pos = 1;
                    1: pos = len;
                    default: pos = $urandom_range(len, 1);
                endcase
            end
        end
        else
        begin
            if ($urandom_range(3) == 0)
            begin
                pos = 0;
            end
            else if (f == FUNC_INSERT)
            begin
                pos = (len + 2 <= 255) ? $urandom_range(255, len + 2) : 0;
            end
            else
            begin
                pos = $urandom_range(255, len + 1);
            end
        end
        issue_command(f, pos, $urandom());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            shadow.check_result(rsp);
        end
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        shadow   = new();
        idle_pct = 24;
        filling  = 1'b1;
        start <= 1'b0;
        req   <= '0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: refusals on the empty list, head and tail inserts, extreme values,
        // out-of-range positions on both sides, then emptying the list again.
        issue_command(FUNC_INSERT, 0, 32'h0000_0001);
        issue_command(FUNC_DELETE, 1, 32'hFFFF_FFFF);
        issue_command(FUNC_DELETE, 0, 32'h0000_0000);
        issue_command(FUNC_INSERT, 1, 32'h0000_0000);
        issue_command(FUNC_INSERT, 1, 32'hFFFF_FFFF);
        issue_command(FUNC_INSERT, 3, 32'hA5A5_5A5A);
        issue_command(FUNC_INSERT, 5, 32'h1234_5678);
        issue_command(FUNC_INSERT, 255, 32'h8000_0000);
        issue_command(FUNC_INSERT, 2, 32'h7FFF_FFFF);
        issue_command(FUNC_DELETE, 4, 32'h0);
        issue_command(FUNC_DELETE, 4, 32'h0);
        issue_command(FUNC_DELETE, 255, 32'h0);
        issue_command(FUNC_DELETE, 2, 32'h0);
        issue_command(FUNC_INSERT, 128, 32'h5555_AAAA);
        issue_command(FUNC_DELETE, 1, 32'h0);
        issue_command(FUNC_DELETE, 1, 32'h0);
        issue_command(FUNC_DELETE, 1, 32'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                idle_pct = 80;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                idle_pct = 0;
            end
            issue_random_command();
        end
        start <= 1'b0;

        while (shadow.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (shadow.mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
